### hw/rtl/websocket_frame_deframer_defines.svh
// Assertion macros for the WebSocket deframer.
// Expects i_clk and i_rst_n in the scope where the macros are used.
`ifndef WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WSD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WSD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/wsd_pkg.sv
// Shared constants and the frame kind decode for the WebSocket deframer.
// No dependencies.
`timescale 1ns / 1ps
package wsd_pkg;

    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 3;
    localparam int OPC_W   = 4;
    localparam int LEN_W   = 64;
    localparam int KEY_W   = 32;

    // Frame kind codes reported with frame_done.
    localparam logic [KIND_W-1:0] KIND_TEXT   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_BINARY = 3'd1;
    localparam logic [KIND_W-1:0] KIND_CLOSE  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_PING   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_PONG   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_MORE   = 3'd5;
    localparam logic [KIND_W-1:0] KIND_ERROR  = 3'd6;

    // Opcodes.
    localparam logic [OPC_W-1:0] OPC_CONT   = 4'h0;
    localparam logic [OPC_W-1:0] OPC_TEXT   = 4'h1;
    localparam logic [OPC_W-1:0] OPC_BINARY = 4'h2;
    localparam logic [OPC_W-1:0] OPC_CLOSE  = 4'h8;
    localparam logic [OPC_W-1:0] OPC_PING   = 4'h9;
    localparam logic [OPC_W-1:0] OPC_PONG   = 4'hA;

    // Seven-bit length codes that select an extended length field.
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    // Last extended-length byte index for each form.
    localparam logic [2:0] EXT16_LAST = 3'd1;
    localparam logic [2:0] EXT64_LAST = 3'd7;

    function automatic logic [KIND_W-1:0] frame_kind_of(
        input logic             fin,
        input logic [OPC_W-1:0] opcode,
        input logic             is_text
    );
        logic [KIND_W-1:0] kind;
        if (!fin) begin
            kind = KIND_MORE;
        end else begin
            case (opcode)
                OPC_CONT:   kind = is_text ? KIND_TEXT : KIND_BINARY;
                OPC_TEXT:   kind = KIND_TEXT;
                OPC_BINARY: kind = KIND_BINARY;
                OPC_CLOSE:  kind = KIND_CLOSE;
                OPC_PING:   kind = KIND_PING;
                OPC_PONG:   kind = KIND_PONG;
                default:    kind = KIND_ERROR;
            endcase
        end
        return kind;
    endfunction

endpackage

### hw/rtl/websocket_frame_deframer.sv
// WebSocket frame deframer: header parse, unmasking and end-of-frame report.
// Depends on wsd_pkg and websocket_frame_deframer_defines.svh.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_stream_byte) carries the raw
//   stream, one byte per transaction. Output channel (o_out_valid /
//   i_out_ready) carries one result transaction for every payload byte and
//   for every byte that ends a frame; other header bytes give no result.
//   A result holds the unmasked byte (o_has_payload, o_payload_out) and the
//   end-of-frame report (o_frame_done, o_frame_kind).
// Each result is registered, shown the cycle after its byte is accepted.
// Throughput: one byte per cycle unless stalled. Each byte passes through
//   one level of parse logic into the parser state and the output register;
//   the widest path is the 64-bit length decrement and zero compare.
// Stall: o_in_ready = output register empty or being drained, so a waiting
//   result blocks input only while i_out_ready stays low.
// Reset (synchronous, active low): parser returns to the first header byte,
//   length, key, flags and the remembered text flag clear, and the output
//   register empties.
`timescale 1ns / 1ps
`include "websocket_frame_deframer_defines.svh"
module websocket_frame_deframer (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [wsd_pkg::BYTE_W-1:0]   i_stream_byte,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_has_payload,
    output logic [wsd_pkg::BYTE_W-1:0]   o_payload_out,
    output logic                         o_frame_done,
    output logic [wsd_pkg::KIND_W-1:0]   o_frame_kind
);
    import wsd_pkg::*;

    typedef enum logic [2:0] {
        PH_HDR0    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_EXT16   = 3'd2,
        PH_EXT64   = 3'd3,
        PH_MASK    = 3'd4,
        PH_PAYLOAD = 3'd5
    } t_phase;

    // Parser state
    t_phase            r_phase,     n_phase;
    logic [2:0]        r_ext_cnt,   n_ext_cnt;
    logic [LEN_W-1:0]  r_remaining, n_remaining;
    logic [KEY_W-1:0]  r_mask_key,  n_mask_key;
    logic [1:0]        r_mask_idx,  n_mask_idx;
    logic              r_fin,       n_fin;
    logic [OPC_W-1:0]  r_opcode,    n_opcode;
    logic              r_masked,    n_masked;
    logic              r_is_text,   n_is_text;

    // Output register
    logic              r_out_valid;
    logic              r_has_payload, n_has_payload;
    logic [BYTE_W-1:0] r_payload,     n_payload;
    logic              r_done,        n_done;
    logic [KIND_W-1:0] r_kind;

    logic              n_emit;
    logic              w_accept;
    logic [LEN_W-1:0]  w_ext_len;
    logic [BYTE_W-1:0] w_key_byte;
    logic [LEN_W-1:0]  w_rem_dec;
    logic [2:0]        w_ext_last;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_ext_len  = {r_remaining[LEN_W-BYTE_W-1:0], i_stream_byte};
    assign w_key_byte = r_mask_key[{r_mask_idx, 3'b000} +: BYTE_W];
    assign w_rem_dec  = (r_remaining != '0) ? (r_remaining - LEN_W'(1)) : r_remaining;
    assign w_ext_last = (r_phase == PH_EXT16) ? EXT16_LAST : EXT64_LAST;

    always_comb begin
        n_phase       = r_phase;
        n_ext_cnt     = r_ext_cnt;
        n_remaining   = r_remaining;
        n_mask_key    = r_mask_key;
        n_mask_idx    = r_mask_idx;
        n_fin         = r_fin;
        n_opcode      = r_opcode;
        n_masked      = r_masked;
        n_emit        = 1'b0;
        n_has_payload = 1'b0;
        n_payload     = '0;
        n_done        = 1'b0;

        case (r_phase)
            PH_HDR1: begin
                n_masked  = i_stream_byte[7];
                n_ext_cnt = '0;
                if (i_stream_byte[6:0] == LEN_EXT16) begin
                    n_remaining = '0;
                    n_phase     = PH_EXT16;
                end else if (i_stream_byte[6:0] == LEN_EXT64) begin
                    n_remaining = '0;
                    n_phase     = PH_EXT64;
                end else begin
                    n_remaining = LEN_W'(i_stream_byte[6:0]);
                    n_mask_idx  = '0;
                    if (i_stream_byte[7]) begin
                        n_mask_key = '0;
                        n_phase    = PH_MASK;
                    end else if (i_stream_byte[6:0] == 7'd0) begin
                        n_emit  = 1'b1;
                        n_done  = 1'b1;
                        n_phase = PH_HDR0;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end
            end
            PH_EXT16, PH_EXT64: begin
                n_remaining = w_ext_len;
                if (r_ext_cnt == w_ext_last) begin
                    n_ext_cnt  = '0;
                    n_mask_idx = '0;
                    if (r_masked) begin
                        n_mask_key = '0;
                        n_phase    = PH_MASK;
                    end else if (w_ext_len == '0) begin
                        n_emit  = 1'b1;
                        n_done  = 1'b1;
                        n_phase = PH_HDR0;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end else begin
                    n_ext_cnt = r_ext_cnt + 3'd1;
                end
            end
            PH_MASK: begin
                n_mask_key[{r_mask_idx, 3'b000} +: BYTE_W] = w_key_byte | i_stream_byte;
                if (r_mask_idx == 2'd3) begin
                    n_mask_idx = '0;
                    if (r_remaining == '0) begin
                        n_emit  = 1'b1;
                        n_done  = 1'b1;
                        n_phase = PH_HDR0;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end else begin
                    n_mask_idx = r_mask_idx + 2'd1;
                end
            end
            PH_PAYLOAD: begin
                n_emit        = 1'b1;
                n_has_payload = 1'b1;
                n_payload     = r_masked ? (i_stream_byte ^ w_key_byte) : i_stream_byte;
                n_mask_idx    = r_mask_idx + 2'd1;
                n_remaining   = w_rem_dec;
                if (w_rem_dec == '0) begin
                    n_done  = 1'b1;
                    n_phase = PH_HDR0;
                end
            end
            default: begin
                // First header byte; unused phase codes land here too.
                n_fin    = i_stream_byte[7];
                n_opcode = i_stream_byte[3:0];
                n_phase  = PH_HDR1;
            end
        endcase

        // Fragment start updates the remembered message type on its end.
        n_is_text = r_is_text;
        if (n_done && !r_fin) begin
            if (r_opcode == OPC_TEXT) begin
                n_is_text = 1'b1;
            end else if (r_opcode == OPC_BINARY) begin
                n_is_text = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HDR0;
            r_ext_cnt   <= '0;
            r_remaining <= '0;
            r_mask_key  <= '0;
            r_mask_idx  <= '0;
            r_fin       <= 1'b0;
            r_opcode    <= '0;
            r_masked    <= 1'b0;
            r_is_text   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                // Advance the parser and load the result register together.
                r_phase     <= n_phase;
                r_ext_cnt   <= n_ext_cnt;
                r_remaining <= n_remaining;
                r_mask_key  <= n_mask_key;
                r_mask_idx  <= n_mask_idx;
                r_fin       <= n_fin;
                r_opcode    <= n_opcode;
                r_masked    <= n_masked;
                r_is_text   <= n_is_text;
                r_out_valid <= n_emit;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload: no reset, loaded only with a result.
    always_ff @(posedge i_clk) begin
        if (w_accept && n_emit) begin
            r_has_payload <= n_has_payload;
            r_payload     <= n_payload;
            r_done        <= n_done;
            r_kind        <= n_done ? frame_kind_of(r_fin, r_opcode, r_is_text) : KIND_TEXT;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_has_payload = r_has_payload;
    assign o_payload_out = r_payload;
    assign o_frame_done  = r_done;
    assign o_frame_kind  = r_kind;

    // A result without a payload byte can only be a zero-length frame end.
    `WSD_ASSERT_IMP(a_empty_result_ends_frame, o_out_valid && !o_has_payload, o_frame_done, "result with neither payload nor frame end")
    // Kind is zero unless the frame ends.
    `WSD_ASSERT_IMP(a_kind_zero_mid_frame, o_out_valid && !o_frame_done, o_frame_kind == KIND_TEXT, "frame kind set on mid-frame byte")
    // A byte that ends a frame returns the parser to the first header byte.
    `WSD_ASSERT_NXT(a_done_returns_to_hdr0, w_accept && n_done, r_phase == PH_HDR0, "parser did not restart after frame end")
    // No result comes from the first header byte.
    `WSD_ASSERT_NXT(a_hdr0_no_result, w_accept && r_phase == PH_HDR0, !o_out_valid, "result produced by first header byte")

endmodule
